@@ sv/tcw_pkg.sv @@
package tcw_pkg;

    localparam int SCREEN_ROWS_DEF    = 30;
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int TAB_STOP_DEF       = 4;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int RD_ROW_W   = 5;
    localparam int RD_COL_W   = 7;
    localparam int CELL_W     = 16;
    localparam int CUR_ROW_W  = 5;
    localparam int CUR_COL_W  = 7;
    localparam int ATTR_W     = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

endpackage

@@ sv/tcw_cmd_if.sv @@
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_byte;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_column;

    modport source (output valid, func, char_byte, read_row, read_column, input ready);
    modport sink   (input valid, func, char_byte, read_row, read_column, output ready);
endinterface

@@ sv/tcw_res_if.sv @@
interface tcw_res_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_word;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_column;
    logic                 scrolled;

    modport source (output valid, cell_word, cursor_row, cursor_column, scrolled, input ready);
    modport sink   (input valid, cell_word, cursor_row, cursor_column, scrolled, output ready);
endinterface

@@ sv/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2400
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/text_console_writer_top.sv @@
// Text console writer: a screen of attribute/character cells plus a cursor.
// Commands arrive on i_cmd (put character, clear screen, read cell or nop);
// every command returns exactly one transaction on o_res with the cell word
// (read only, else zero), the cursor after the command and a scrolled flag.
// The colour attribute is written through i_cfg_we/i_cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// A scroll copies the screen up one row, one cell copied per cycle, then
// blanks the bottom row one cell per cycle. The cell store has a single
// write port, so cells are written one per cycle. One command is in flight
// at a time; i_cmd.ready is high only when the sequencer is idle, which it
// enters in the cycle after the previous result is loaded.
// After reset all ROWS*COLUMNS cells of the store (2400 by default) are
// cleared, one cell per cycle, before the first command is taken.
// A finished result sits in an output register; a stalled receiver holds it
// and the next command may run, but its result waits until o_res drains.
module text_console_writer_top #(
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int TAB_STOP       = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tcw_cmd_if.sink                   i_cmd,
    tcw_res_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS + 1);
    localparam int CW    = $clog2(SCREEN_COLUMNS + 1);
    localparam int TW    = $clog2(TAB_STOP + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WRAP, S_SCRCHK, S_SCR, S_SCR_DRAIN, S_BLANK,
        S_ACT, S_CLEAR, S_RD, S_RWAIT, S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [RW-1:0]        r_row, n_row;
    logic [CW-1:0]        r_col, n_col;
    logic [TW-1:0]        r_phase, n_phase;
    logic [TW-1:0]        r_tab_cnt, n_tab_cnt;
    logic                 r_tab_start, n_tab_start;
    logic [CHAR_W-1:0]    r_ch, n_ch;
    logic [ATTR_W-1:0]    r_attr, n_attr;
    logic                 r_scrolled, n_scrolled;
    logic [AW-1:0]        r_src, n_src;
    logic [AW-1:0]        r_dst, n_dst;
    logic                 r_pend, n_pend;
    logic                 r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]    r_cell, n_cell;

    logic                 r_o_valid, n_o_valid;
    logic [CELL_W-1:0]    r_o_cell, n_o_cell;
    logic [CUR_ROW_W-1:0] r_o_row, n_o_row;
    logic [CUR_COL_W-1:0] r_o_col, n_o_col;
    logic                 r_o_scr, n_o_scr;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [CELL_W-1:0]    w_wdata;
    logic [CELL_W-1:0]    w_rdata;
    logic [AW-1:0]        w_cur_addr;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_rd_in_range;
    logic                 w_plain;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_src),
        .o_rdata (w_rdata)
    );

    assign w_cur_addr    = AW'(int'(r_row) * SCREEN_COLUMNS + int'(r_col));
    assign w_rd_addr     = AW'(int'(i_cmd.read_row) * SCREEN_COLUMNS + int'(i_cmd.read_column));
    assign w_rd_in_range = (int'(i_cmd.read_row) < SCREEN_ROWS) &&
                           (int'(i_cmd.read_column) < SCREEN_COLUMNS);
    // a printable cell write (not newline/return, not the tab setup pass)
    assign w_plain       = !r_tab_start && (r_ch != CH_NEWLINE) && (r_ch != CH_RETURN);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_src;
        w_wdata = '0;
        case (r_state)
            S_INIT, S_CLEAR, S_BLANK: begin
                w_we = 1'b1;
            end
            S_SCR, S_SCR_DRAIN: begin
                w_we    = r_pend;
                w_waddr = r_dst;
                w_wdata = w_rdata;
            end
            S_ACT: begin
                w_we    = w_plain;
                w_waddr = w_cur_addr;
                w_wdata = {r_attr, r_ch};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_tab_cnt   = r_tab_cnt;
        n_tab_start = r_tab_start;
        n_ch        = r_ch;
        n_attr      = i_cfg_we ? i_cfg_data : r_attr;
        n_scrolled  = r_scrolled;
        n_src       = r_src;
        n_dst       = r_dst;
        n_pend      = 1'b0;
        n_rd_ok     = r_rd_ok;
        n_cell      = r_cell;
        n_o_valid   = r_o_valid && !o_res.ready;
        n_o_cell    = r_o_cell;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_scr     = r_o_scr;

        case (r_state)
            S_INIT: begin
                if (r_src == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_scrolled = 1'b0;
                    n_cell     = '0;
                    case (t_func'(i_cmd.func))
                        FUNC_PUT: begin
                            n_ch        = i_cmd.char_byte;
                            n_tab_start = (i_cmd.char_byte == CH_TAB);
                            n_tab_cnt   = '0;
                            n_state     = S_WRAP;
                        end
                        FUNC_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_phase = '0;
                            n_src   = '0;
                            n_state = S_CLEAR;
                        end
                        FUNC_READ: begin
                            n_src   = w_rd_addr;
                            n_rd_ok = w_rd_in_range;
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WRAP: begin
                if (r_col >= CW'(SCREEN_COLUMNS)) begin
                    n_row   = r_row + 1'b1;
                    n_col   = '0;
                    n_phase = '0;
                end
                n_state = S_SCRCHK;
            end
            S_SCRCHK: begin
                if (r_row >= RW'(SCREEN_ROWS)) begin
                    n_row      = RW'(SCREEN_ROWS - 1);
                    n_scrolled = 1'b1;
                    n_src      = AW'(SCREEN_COLUMNS);
                    n_state    = S_SCR;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_SCR: begin
                // read cell k, write it one row up on the next cycle
                n_pend = 1'b1;
                n_dst  = r_src - AW'(SCREEN_COLUMNS);
                if (r_src == AW'(CELLS - 1)) begin
                    n_state = S_SCR_DRAIN;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_SCR_DRAIN: begin
                n_src   = AW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
                n_state = S_BLANK;
            end
            S_BLANK: begin
                if (r_src == AW'(CELLS - 1)) begin
                    n_state = S_ACT;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_ACT: begin
                if (r_tab_start) begin
                    n_tab_start = 1'b0;
                    n_tab_cnt   = TW'(TAB_STOP) - r_phase;
                    n_ch        = CH_SPACE;
                    n_state     = S_WRAP;
                end else if (r_ch == CH_NEWLINE) begin
                    n_row   = r_row + 1'b1;
                    n_col   = '0;
                    n_phase = '0;
                    n_state = S_DONE;
                end else if (r_ch == CH_RETURN) begin
                    n_col   = '0;
                    n_phase = '0;
                    n_state = S_DONE;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_phase = (r_phase == TW'(TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
                    if (r_tab_cnt > TW'(1)) begin
                        n_tab_cnt = r_tab_cnt - 1'b1;
                        n_state   = S_WRAP;
                    end else begin
                        n_tab_cnt = '0;
                        n_state   = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                if (r_src == AW'(CELLS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_RD: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_cell  = r_rd_ok ? w_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid = 1'b1;
                    n_o_cell  = r_cell;
                    n_o_row   = CUR_ROW_W'(r_row);
                    n_o_col   = CUR_COL_W'(r_col);
                    n_o_scr   = r_scrolled;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_tab_cnt   <= '0;
            r_tab_start <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_scrolled  <= 1'b0;
            r_src       <= '0;
            r_pend      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_tab_cnt   <= n_tab_cnt;
            r_tab_start <= n_tab_start;
            r_attr      <= n_attr;
            r_scrolled  <= n_scrolled;
            r_src       <= n_src;
            r_pend      <= n_pend;
            r_o_valid   <= n_o_valid;
        end
        r_ch     <= n_ch;
        r_dst    <= n_dst;
        r_rd_ok  <= n_rd_ok;
        r_cell   <= n_cell;
        r_o_cell <= n_o_cell;
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_scr  <= n_o_scr;
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.cell_word     = r_o_cell;
    assign o_res.cursor_row    = r_o_row;
    assign o_res.cursor_column = r_o_col;
    assign o_res.scrolled      = r_o_scr;

    // cell writes only happen with the cursor on screen
    a_act_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT) |-> (r_row < RW'(SCREEN_ROWS)) && (r_col < CW'(SCREEN_COLUMNS)))
        else $error("cursor off screen at cell write");

    // copy write pending only inside the scroll copy
    a_pend_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCR) || (r_state == S_SCR_DRAIN))
        else $error("stray scroll copy write");

    a_tab_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tab_cnt <= TW'(TAB_STOP)) && (r_phase < TW'(TAB_STOP)))
        else $error("tab counter out of range");

    // no result may appear before the power-up clear finishes
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_o_valid)
        else $error("result during initial clear");

    // a scroll always ends with the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_DRAIN) |=> (r_row == RW'(SCREEN_ROWS - 1)))
        else $error("cursor not on bottom row after scroll");
endmodule
